/* rtl/dmix_pkg.sv */
// Shared types and constants of the DAC mixer.
`default_nettype none

package dmix_pkg;

	// Item command codes.
	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_UBYTE  = 3'd1;
	localparam logic [2:0] CMD_SBYTE  = 3'd2;
	localparam logic [2:0] CMD_WORD   = 3'd3;
	localparam logic [2:0] CMD_STEREO = 3'd4;
	localparam logic [2:0] CMD_OFFBIN = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] CFG_GAINS_LOW  = 3'd0;
	localparam logic [2:0] CFG_GAINS_HIGH = 3'd1;
	localparam logic [2:0] CFG_ROUTES     = 3'd2;
	localparam logic [2:0] CFG_STEREO     = 3'd3;
	localparam logic [2:0] CFG_ENABLE     = 3'd4;
	localparam logic [2:0] CFG_DC_BLOCK   = 3'd5;
	localparam logic [2:0] CFG_ADD_INPUT  = 3'd6;

	localparam int CFG_DATA_W = 64;

	// Reset values of the configuration registers.
	localparam logic [63:0] GAIN_RESET   = 64'h4000_4000_4000_4000;
	localparam logic [15:0] ROUTES_RESET = 16'hFFFF;

	// 0.998 in Q0.16, rounded to nearest.
	localparam logic [15:0] DC_COEF = 16'd65405;

	// Operations of the shared arithmetic unit.
	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_MUL = 1'b1;

	typedef struct packed {
		logic op;       // ALU_ADD or ALU_MUL
		logic shift16;  // multiply: divide by 65536 instead of 16384
	} alu_req_t;

endpackage

`default_nettype wire

/* rtl/dmix_if.sv */
// Valid/ready channel interfaces for mixer items and mixer results.
`default_nettype none

interface dmix_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic [2:0]         channel;
	logic [15:0]        value_a;
	logic [15:0]        value_b;
	logic signed [15:0] mix_in_left;
	logic signed [15:0] mix_in_right;

	modport source (
		output valid, command, channel, value_a, value_b, mix_in_left, mix_in_right,
		input  ready
	);
	modport sink (
		input  valid, command, channel, value_a, value_b, mix_in_left, mix_in_right,
		output ready
	);
endinterface

interface dmix_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_left;
	logic signed [15:0] out_right;

	modport source (
		output valid, out_left, out_right,
		input  ready
	);
	modport sink (
		input  valid, out_left, out_right,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/multichannel_dac_mixer_unit.sv */
// Top level of the multichannel DAC mixer with DC blocking filter.
//
//   port     | role   | transaction
//   ---------+--------+-----------------------------------------------------
//   item     | sink   | tick or level write: command, channel, values, mix_in
//   result   | source | one mixed stereo sample pair per tick
//   cfg_*    | write  | one configuration register, taken in the same cycle
//
// A level write is accepted, then the shared unit performs one multiply per
// stored level (two for a stereo write). A tick mixes both sides of every
// channel, runs the DC blocker and the add-input step when each is enabled,
// and loads the output register. The pace is set by the single shared
// arithmetic unit, which performs one saturating add or one multiply per cycle.
// Reset clears the configuration to its defaults, all levels and the filter
// history to zero. A stalled result holds in the output register; level
// writes are still taken meanwhile, and the next tick waits in its last step.
`default_nettype none

module multichannel_dac_mixer_unit
	import dmix_pkg::*;
#(
	parameter int NUM_CHANNELS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	dmix_item_if.sink                  item,
	dmix_result_if.source              result
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// Sequencer states.
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCALE_A = 4'd1;
	localparam logic [3:0] S_SCALE_B = 4'd2;
	localparam logic [3:0] S_MIX     = 4'd3;
	localparam logic [3:0] S_DCL_MUL = 4'd4;
	localparam logic [3:0] S_DCL_ADD = 4'd5;
	localparam logic [3:0] S_DCR_MUL = 4'd6;
	localparam logic [3:0] S_DCR_ADD = 4'd7;
	localparam logic [3:0] S_ADD_L   = 4'd8;
	localparam logic [3:0] S_ADD_R   = 4'd9;
	localparam logic [3:0] S_FIN     = 4'd10;

	// Configuration registers.
	logic [63:0] gains_low_q;
	logic [63:0] gains_high_q;
	logic [15:0] routes_q;
	logic [7:0]  stereo_q;
	logic [7:0]  enable_q;
	logic        dc_en_q;
	logic        add_en_q;

	// Sequencer and accumulators.
	logic [3:0]         state_q;
	logic [CH_W-1:0]    cnt_q;
	logic               side_q;
	logic signed [15:0] acc_l_q;
	logic signed [15:0] acc_r_q;
	logic signed [15:0] fb_q;

	// Latched item.
	logic [2:0]         cmd_q;
	logic [2:0]         ch_q;
	logic [15:0]        val_a_q;
	logic [15:0]        val_b_q;
	logic signed [15:0] mix_l_q;
	logic signed [15:0] mix_r_q;

	// Channel levels and filter history.
	logic signed [15:0] lvl_first_q  [NUM_CHANNELS];
	logic signed [15:0] lvl_second_q [NUM_CHANNELS];
	logic signed [15:0] prev_in_l_q;
	logic signed [15:0] prev_out_l_q;
	logic signed [15:0] prev_in_r_q;
	logic signed [15:0] prev_out_r_q;

	// Output register.
	logic               out_valid_q;
	logic signed [15:0] out_l_q;
	logic signed [15:0] out_r_q;

	// Shared unit request.
	alu_req_t           alu_req;
	logic signed [15:0] alu_a;
	logic [15:0]        alu_b;
	logic signed [15:0] alu_c;
	logic signed [15:0] alu_res;

	logic               item_acc;
	logic               out_load;
	logic [2:0]         mix_ch;
	logic [15:0]        route_sh;
	logic               ch_on;
	logic               last_ch;
	logic [127:0]       gains_all;
	logic [15:0]        gain;
	logic [15:0]        sample_a;
	logic [3:0]         after_mix;
	logic [3:0]         after_dc;

	assign item.ready = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign out_load   = (state_q == S_FIN) && (!out_valid_q || result.ready);

	assign result.valid     = out_valid_q;
	assign result.out_left  = out_l_q;
	assign result.out_right = out_r_q;

	assign mix_ch    = 3'(cnt_q);
	assign route_sh  = routes_q >> {mix_ch, 1'b0};
	assign ch_on     = enable_q[mix_ch] && (side_q ? route_sh[1] : route_sh[0]);
	assign last_ch   = (cnt_q == CH_W'(NUM_CHANNELS - 1));
	assign gains_all = {gains_high_q, gains_low_q};
	assign gain      = gains_all[{ch_q, 4'b0000} +: 16];

	assign after_dc  = add_en_q ? S_ADD_L : S_FIN;
	assign after_mix = dc_en_q ? S_DCL_MUL : after_dc;

	// Convert the write data to a signed 16-bit sample.
	always_comb begin
		case (cmd_q)
			CMD_UBYTE: sample_a = {1'b0, val_a_q[7:0], val_a_q[7:1]};
			CMD_SBYTE: sample_a = {~val_a_q[7], val_a_q[6:0], val_a_q[7:0]};
			CMD_OFFBIN: sample_a = val_a_q ^ 16'h8000;
			default: sample_a = val_a_q;
		endcase
	end

	// Operand selection for the shared unit.
	always_comb begin
		alu_req.op      = ALU_ADD;
		alu_req.shift16 = 1'b0;
		alu_a           = acc_l_q;
		alu_b           = '0;
		alu_c           = '0;
		case (state_q)
			S_SCALE_A: begin
				alu_req.op = ALU_MUL;
				alu_a      = sample_a;
				alu_b      = gain;
			end
			S_SCALE_B: begin
				alu_req.op = ALU_MUL;
				alu_a      = val_b_q;
				alu_b      = gain;
			end
			S_MIX: begin
				if (side_q) begin
					alu_a = acc_r_q;
					alu_b = stereo_q[mix_ch] ? lvl_second_q[cnt_q] : lvl_first_q[cnt_q];
				end else begin
					alu_b = lvl_first_q[cnt_q];
				end
			end
			S_DCL_MUL: begin
				alu_req.op      = ALU_MUL;
				alu_req.shift16 = 1'b1;
				alu_a           = prev_out_l_q;
				alu_b           = DC_COEF;
			end
			S_DCL_ADD: begin
				alu_b = fb_q;
				alu_c = prev_in_l_q;
			end
			S_DCR_MUL: begin
				alu_req.op      = ALU_MUL;
				alu_req.shift16 = 1'b1;
				alu_a           = prev_out_r_q;
				alu_b           = DC_COEF;
			end
			S_DCR_ADD: begin
				alu_a = acc_r_q;
				alu_b = fb_q;
				alu_c = prev_in_r_q;
			end
			S_ADD_L: begin
				alu_b = mix_l_q;
			end
			S_ADD_R: begin
				alu_a = acc_r_q;
				alu_b = mix_r_q;
			end
			default: begin
			end
		endcase
	end

	dmix_alu u_alu (
		.req (alu_req),
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.res (alu_res)
	);

	// The host must write configuration registers only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_low_q  <= GAIN_RESET;
			gains_high_q <= GAIN_RESET;
			routes_q     <= ROUTES_RESET;
			stereo_q     <= '0;
			enable_q     <= '0;
			dc_en_q      <= 1'b0;
			add_en_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAINS_LOW: gains_low_q <= cfg_data;
				CFG_GAINS_HIGH: gains_high_q <= cfg_data;
				CFG_ROUTES: routes_q <= cfg_data[15:0];
				CFG_STEREO: stereo_q <= cfg_data[7:0];
				CFG_ENABLE: enable_q <= cfg_data[7:0];
				CFG_DC_BLOCK: dc_en_q <= cfg_data[0];
				CFG_ADD_INPUT: add_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Item payload is captured on accept, the filter product and output samples as they are produced; none needs a reset.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			cmd_q   <= item.command;
			ch_q    <= item.channel;
			val_a_q <= item.value_a;
			val_b_q <= item.value_b;
			mix_l_q <= item.mix_in_left;
			mix_r_q <= item.mix_in_right;
		end
		if (state_q == S_DCL_MUL || state_q == S_DCR_MUL) begin
			fb_q <= alu_res;
		end
		if (out_load) begin
			out_l_q <= acc_l_q;
			out_r_q <= acc_r_q;
		end
	end

	// Sequencer, levels and filter history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			side_q       <= 1'b0;
			acc_l_q      <= '0;
			acc_r_q      <= '0;
			prev_in_l_q  <= '0;
			prev_out_l_q <= '0;
			prev_in_r_q  <= '0;
			prev_out_r_q <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				lvl_first_q[i]  <= '0;
				lvl_second_q[i] <= '0;
			end
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						cnt_q   <= '0;
						side_q  <= 1'b0;
						acc_l_q <= '0;
						acc_r_q <= '0;
						if (item.command == CMD_TICK) begin
							state_q <= S_MIX;
						end else if (item.command <= CMD_OFFBIN &&
								{1'b0, item.channel} < 4'(NUM_CHANNELS)) begin
							state_q <= S_SCALE_A;
						end
					end
				end
				S_SCALE_A: begin
					lvl_first_q[ch_q[CH_W-1:0]] <= alu_res;
					state_q <= (cmd_q == CMD_STEREO) ? S_SCALE_B : S_IDLE;
				end
				S_SCALE_B: begin
					lvl_second_q[ch_q[CH_W-1:0]] <= alu_res;
					state_q <= S_IDLE;
				end
				S_MIX: begin
					// Left and right of each channel are added in turn, left first.
					if (ch_on) begin
						if (side_q) begin
							acc_r_q <= alu_res;
						end else begin
							acc_l_q <= alu_res;
						end
					end
					side_q <= !side_q;
					if (side_q) begin
						if (last_ch) begin
							state_q <= after_mix;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_DCL_MUL: state_q <= S_DCL_ADD;
				S_DCL_ADD: begin
					prev_in_l_q  <= acc_l_q;
					prev_out_l_q <= alu_res;
					acc_l_q      <= alu_res;
					state_q      <= S_DCR_MUL;
				end
				S_DCR_MUL: state_q <= S_DCR_ADD;
				S_DCR_ADD: begin
					prev_in_r_q  <= acc_r_q;
					prev_out_r_q <= alu_res;
					acc_r_q      <= alu_res;
					state_q      <= after_dc;
				end
				S_ADD_L: begin
					acc_l_q <= alu_res;
					state_q <= S_ADD_R;
				end
				S_ADD_R: begin
					acc_r_q <= alu_res;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// Wait here until the output register is free.
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A new result only ever appears from the final sequencer step.
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result raised outside the final step");

	// An empty output register is always loaded from the final step.
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
		else $error("final step did not load an empty output register");

	// A tick starts the mix at the first channel, left side.
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.command == CMD_TICK) |=>
			(state_q == S_MIX && cnt_q == '0 && !side_q && acc_l_q == '0 && acc_r_q == '0))
		else $error("tick did not start the mix cleanly");

endmodule

`default_nettype wire

/* rtl/dmix_alu.sv */
// Shared arithmetic unit: saturating three-operand add or scaled multiply.
`default_nettype none

module dmix_alu
	import dmix_pkg::*;
(
	input  wire alu_req_t           req,
	input  wire logic signed [15:0] a,
	input  wire logic [15:0]        b,
	input  wire logic signed [15:0] c,
	output logic signed [15:0]      res
);

	logic signed [32:0] prod;
	logic signed [32:0] bias;
	logic signed [32:0] biased;
	logic signed [32:0] quot;
	logic signed [17:0] sum;

	always_comb begin
		// Multiply: signed a by unsigned b, divided by a power of two with
		// truncation toward zero, then wrapped to 16 bits.
		prod = $signed({a[15], a}) * $signed({1'b0, b});
		if (prod[32]) begin
			bias = req.shift16 ? 33'sd65535 : 33'sd16383;
		end else begin
			bias = '0;
		end
		biased = prod + bias;
		quot   = req.shift16 ? (biased >>> 16) : (biased >>> 14);

		// Add: a + b - c with b read as two's complement.
		sum = {{2{a[15]}}, a} + {{2{b[15]}}, b} - {{2{c[15]}}, c};

		if (req.op == ALU_MUL) begin
			res = quot[15:0];
		end else if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111) begin
			res = sum[15:0];
		end else begin
			res = sum[17] ? 16'sh8000 : 16'sh7FFF;
		end
	end

endmodule

`default_nettype wire
